// ===== hdl/porter_duff_compositor_assert.svh =====
// Assertion macros for the Porter-Duff compositor.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PORTER_DUFF_COMPOSITOR_ASSERT_SVH
`define PORTER_DUFF_COMPOSITOR_ASSERT_SVH
`ifndef SYNTHESIS
// check while out of reset
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also covers cycles in reset
`define PDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDC_ASSERT(lbl, prop, msg)
`define PDC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hdl/pdc_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the compositor.
// No dependencies; used by every module of the block.
`default_nettype none

package pdc_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned IN_DATA_W  = 2 * NUM_CHAN * CHAN_W;
  localparam int unsigned OUT_DATA_W = NUM_CHAN * CHAN_W;
  localparam logic [7:0]  MAX_VAL    = 8'hFF;

  typedef enum logic [2:0] {
    MODE_OVER = 3'd0,
    MODE_IN   = 3'd1,
    MODE_OUT  = 3'd2,
    MODE_ATOP = 3'd3,
    MODE_XOR  = 3'd4
  } blend_mode_t;

  typedef enum logic [1:0] {
    REG_BLEND_MODE       = 2'd0,
    REG_FIRST_HAS_ALPHA  = 2'd1,
    REG_SECOND_HAS_ALPHA = 2'd2
  } reg_idx_t;

  // where a channel of the result comes from
  typedef enum logic [1:0] {
    SRC_FIRST  = 2'd0,
    SRC_SECOND = 2'd1,
    SRC_ZERO   = 2'd2,
    SRC_BLEND  = 2'd3
  } src_t;

  typedef struct packed {
    logic [2:0] blend_mode;
    logic       first_has_alpha;
    logic       second_has_alpha;
  } cfg_t;

  // per-pixel blend control: result = sat((wf*F + ws*S) / 255)
  typedef struct packed {
    src_t       color_src;
    src_t       alpha_src;
    logic [7:0] wf;
    logic [7:0] ws;
  } ctl_t;

  // floor(x / 255) for x < 2^17: reciprocal estimate, then one correction step
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [25:0] est;
    logic [8:0]  q;
    logic [16:0] rem;
    est = {9'b0, x} + {1'b0, x, 8'b0};
    q   = est[24:16];
    rem = x - ({q, 8'b0} - {8'b0, q});
    if (rem >= {9'b0, MAX_VAL}) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pdc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on pdc_pkg for register codes and the config struct.
`default_nettype none

module pdc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pdc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pdc_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [pdc_pkg::CFG_DATA_W-1:0] prdata,
  output      pdc_pkg::cfg_t                  cfg
);

  pdc_pkg::cfg_t cfg_r;
  pdc_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        pdc_pkg::REG_BLEND_MODE:       cfg_nxt.blend_mode       = pwdata[2:0];
        pdc_pkg::REG_FIRST_HAS_ALPHA:  cfg_nxt.first_has_alpha  = pwdata[0];
        pdc_pkg::REG_SECOND_HAS_ALPHA: cfg_nxt.second_has_alpha = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_mode       <= pdc_pkg::MODE_OVER;
      cfg_r.first_has_alpha  <= 1'b1;
      cfg_r.second_has_alpha <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      pdc_pkg::REG_BLEND_MODE:       prdata[2:0] = cfg_r.blend_mode;
      pdc_pkg::REG_FIRST_HAS_ALPHA:  prdata[0]   = cfg_r.first_has_alpha;
      pdc_pkg::REG_SECOND_HAS_ALPHA: prdata[0]   = cfg_r.second_has_alpha;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/pdc_decode.sv =====
// Mode decode: picks channel sources and blend weights for one pixel pair.
// Depends on pdc_pkg for mode codes and the control struct.
`default_nettype none

module pdc_decode (
  input  wire pdc_pkg::cfg_t cfg,
  input  wire logic [7:0]    first_alpha,
  input  wire logic [7:0]    second_alpha,
  input  wire logic          in_overlap,
  output      pdc_pkg::ctl_t ctl
);

  logic fa;
  logic sa;
  logic is_over;
  logic is_in;

  assign fa = cfg.first_has_alpha;
  assign sa = cfg.second_has_alpha;

  // atop with one alpha missing degrades to over or in
  assign is_over = (cfg.blend_mode == pdc_pkg::MODE_OVER) ||
                   ((cfg.blend_mode == pdc_pkg::MODE_ATOP) && fa && !sa);
  assign is_in   = (cfg.blend_mode == pdc_pkg::MODE_IN) ||
                   ((cfg.blend_mode == pdc_pkg::MODE_ATOP) && !fa && sa);

  always_comb begin
    ctl.color_src = pdc_pkg::SRC_FIRST;
    ctl.alpha_src = fa ? pdc_pkg::SRC_FIRST : pdc_pkg::SRC_ZERO;
    ctl.wf        = '0;
    ctl.ws        = '0;
    if (cfg.blend_mode == pdc_pkg::MODE_XOR) begin
      if (fa && sa) begin
        if (in_overlap) begin
          ctl.color_src = pdc_pkg::SRC_BLEND;
          ctl.alpha_src = pdc_pkg::SRC_BLEND;
          ctl.wf        = ~second_alpha;
          ctl.ws        = ~first_alpha;
        end else begin
          ctl.color_src = pdc_pkg::SRC_ZERO;
          ctl.alpha_src = pdc_pkg::SRC_ZERO;
        end
      end else if (sa) begin
        ctl.color_src = pdc_pkg::SRC_SECOND;
        ctl.alpha_src = pdc_pkg::SRC_SECOND;
      end else if (!fa) begin
        ctl.color_src = pdc_pkg::SRC_ZERO;
        ctl.alpha_src = pdc_pkg::SRC_ZERO;
      end
    end else if (in_overlap) begin
      if (is_over && fa) begin
        // F + m(255-Fa, S) == (255*F + (255-Fa)*S) / 255
        ctl.color_src = pdc_pkg::SRC_BLEND;
        ctl.alpha_src = sa ? pdc_pkg::SRC_BLEND : pdc_pkg::SRC_FIRST;
        ctl.wf        = pdc_pkg::MAX_VAL;
        ctl.ws        = ~first_alpha;
      end else if ((is_in || (cfg.blend_mode == pdc_pkg::MODE_OUT)) && sa) begin
        ctl.color_src = pdc_pkg::SRC_BLEND;
        ctl.alpha_src = fa ? pdc_pkg::SRC_BLEND : pdc_pkg::SRC_ZERO;
        ctl.wf        = is_in ? second_alpha : ~second_alpha;
      end else if ((cfg.blend_mode == pdc_pkg::MODE_ATOP) && fa && sa) begin
        ctl.color_src = pdc_pkg::SRC_BLEND;
        ctl.alpha_src = pdc_pkg::SRC_SECOND;
        ctl.wf        = second_alpha;
        ctl.ws        = ~first_alpha;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdc_lane.sv =====
// One channel of the blend datapath: two 8x8 products, sum, divide by 255, saturate.
// Depends on pdc_pkg for the divide helper.
`default_nettype none

module pdc_lane (
  input  wire logic [7:0] first_chan,
  input  wire logic [7:0] second_chan,
  input  wire logic [7:0] wf,
  input  wire logic [7:0] ws,
  output      logic [7:0] blend
);

  logic [15:0] prod_f;
  logic [15:0] prod_s;
  logic [16:0] sum;
  logic [8:0]  quot;

  assign prod_f = wf * first_chan;
  assign prod_s = ws * second_chan;
  assign sum    = {1'b0, prod_f} + {1'b0, prod_s};
  assign quot   = pdc_pkg::div255(sum);
  assign blend  = quot[8] ? pdc_pkg::MAX_VAL : quot[7:0];

endmodule

`default_nettype wire

// ===== hdl/porter_duff_compositor.sv =====
// Porter-Duff compositor top level: input register, decode and lanes, result register.
// Depends on pdc_pkg, pdc_cfg_regs, pdc_decode, pdc_lane and the assertion header.
//
//  channel   dir   tdata / tuser                       transaction
//  in_*      in    8 x 8-bit pixel pair / overlap flag one pixel pair
//  out_*     out   4 x 8-bit composited pixel          one pixel
//  cfg_*     in    APB-style, 3 registers at 0x0..0x8  one register write
//
// One pixel pair per clock sustained while out_tready is high; each pair passes the
// input register, then the four-lane multiply/divide datapath into the result register.
// Reset is synchronous: pipeline empties, mode = over, both alpha flags set.
// out_tready low holds the result; one more pair is still taken into the input stage.
`default_nettype none
`include "porter_duff_compositor_assert.svh"

module porter_duff_compositor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // [7:0] first_red, [15:8] first_green, [23:16] first_blue, [31:24] first_alpha,
  // [39:32] second_red, [47:40] second_green, [55:48] second_blue,
  // [63:56] second_alpha
  input  wire logic [pdc_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] in_overlap
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
  output      logic [pdc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [pdc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output      logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output      logic                             cfg_pready
);

  localparam int unsigned CW = pdc_pkg::CHAN_W;
  localparam int unsigned NC = pdc_pkg::NUM_CHAN;

  pdc_pkg::cfg_t                 cfg;
  pdc_pkg::ctl_t                 ctl;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [pdc_pkg::IN_DATA_W-1:0] s1_data_r;
  logic                          s1_ovl_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [pdc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [pdc_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic                          in_xfer;
  logic                          s1_adv;
  logic                          s2_load;
  logic [CW-1:0]                 blend [NC];

  assign cfg_pready = 1'b1;

  pdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // handshake: result register frees when empty or taken
  assign s1_adv    = !out_valid_r || out_tready;
  assign s2_load   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s2_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_tdata;
      s1_ovl_r  <= in_tuser;
    end
    if (s2_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  pdc_decode u_decode (
    .cfg          (cfg),
    .first_alpha  (s1_data_r[3*CW +: CW]),
    .second_alpha (s1_data_r[(NC+3)*CW +: CW]),
    .in_overlap   (s1_ovl_r),
    .ctl          (ctl)
  );

  for (genvar k = 0; k < NC; k++) begin : g_lane
    pdc_lane u_lane (
      .first_chan  (s1_data_r[k*CW +: CW]),
      .second_chan (s1_data_r[(NC+k)*CW +: CW]),
      .wf          (ctl.wf),
      .ws          (ctl.ws),
      .blend       (blend[k])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < NC; k++) begin
      unique case ((k == NC - 1) ? ctl.alpha_src : ctl.color_src)
        pdc_pkg::SRC_FIRST:  out_data_nxt[k*CW +: CW] = s1_data_r[k*CW +: CW];
        pdc_pkg::SRC_SECOND: out_data_nxt[k*CW +: CW] = s1_data_r[(NC+k)*CW +: CW];
        pdc_pkg::SRC_ZERO:   out_data_nxt[k*CW +: CW] = '0;
        pdc_pkg::SRC_BLEND:  out_data_nxt[k*CW +: CW] = blend[k];
        default:             out_data_nxt[k*CW +: CW] = '0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PDC_ASSERT_RST(a_rst_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")
  `PDC_ASSERT(a_ready_room, in_tready |-> !s1_valid_r || s2_load, "input taken while input stage is stuck")
  `PDC_ASSERT(a_over_alpha, s2_load && cfg.blend_mode == pdc_pkg::MODE_OVER && ctl.color_src == pdc_pkg::SRC_BLEND |=> out_data_r[3*CW +: CW] >= $past(s1_data_r[3*CW +: CW]), "over alpha below first alpha")
  `PDC_ASSERT(a_xor_outside, s2_load && cfg.blend_mode == pdc_pkg::MODE_XOR && cfg.first_has_alpha && cfg.second_has_alpha && !s1_ovl_r |=> out_data_r == '0, "xor outside overlap not zero")

endmodule

`default_nettype wire
